// ===== hw/rtl/tocq_pkg.sv =====
// package for the time ordered event queue
// holds command and status codes, sequencer states and the slot layout
// no dependencies
`timescale 1ns / 1ps

package tocq_pkg;

  localparam int unsigned TICK_W = 64;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_FULL     = 2'd2,
    STS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WNEW,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MD_INSERT,
    MD_SEARCH,
    MD_SHIFT,
    MD_HEAD
  } mode_e;

  typedef struct packed {
    logic [TICK_W-1:0]        tick;
    logic signed [PRIO_W-1:0] prio;
    logic [ID_W-1:0]          id;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

// ===== hw/rtl/time_ordered_event_queue_core.sv =====
// time ordered event queue: sorted bounded queue kept in one slot ram
// depends on tocq_pkg and tocq_ram
//
// usage:
// the input channel (in_valid_i / in_stall_o) carries one command per transfer:
// insert an id with due tick and priority, remove the first entry with an id,
// or pop the head. entries stay sorted by tick, then signed priority, with a
// new entry placed ahead of equal keys. every command gives exactly one result
// on the output channel (out_valid_o / out_stall_i): status, the popped entry
// on a successful pop (zero otherwise) and the occupancy after the command.
// the sequencer walks the slot ram one slot at a time (read, then evaluate
// and write back); insert visits the tail down to the slot ahead of its
// position, remove and pop every queued slot; an insert that puts its entry at
// the head or into an empty queue ends with a separate write of the new entry.
// one command is in work at a time; in_stall_o is high while it runs.
// the result sits in an output register, so a new command is taken while an
// earlier result is still stalled; a finished command waits only if that
// register is still full. reset empties the queue and drops any held result;
// the slot ram itself is not cleared.
`timescale 1ns / 1ps

module time_ordered_event_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [tocq_pkg::ID_W-1:0]           event_id_i,
  input  logic [tocq_pkg::TICK_W-1:0]         due_tick_i,
  input  logic signed [tocq_pkg::PRIO_W-1:0]  event_priority_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [tocq_pkg::ID_W-1:0]           head_id_o,
  output logic [tocq_pkg::TICK_W-1:0]         head_tick_o,
  output logic signed [tocq_pkg::PRIO_W-1:0]  head_priority_o,
  output logic [tocq_pkg::OCC_W-1:0]          occupancy_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  tocq_pkg::state_e  state_q, state_d;
  tocq_pkg::mode_e   mode_q, mode_d;
  tocq_pkg::status_e res_status_q, res_status_d;
  tocq_pkg::slot_t   res_slot_q, res_slot_d;
  tocq_pkg::slot_t   new_slot_q;
  tocq_pkg::slot_t   rd_slot;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]   count_q, count_d;

  logic                      out_valid_q;
  tocq_pkg::status_e         out_status_q;
  tocq_pkg::slot_t           out_slot_q;
  logic [tocq_pkg::OCC_W-1:0] out_occ_q;

  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [tocq_pkg::SLOT_W-1:0] ram_wdata;
  logic [AddrW-1:0]            ram_raddr;
  logic [tocq_pkg::SLOT_W-1:0] ram_rdata;

  logic in_xfer;
  logic out_load;
  logic goes_before;
  logic at_tail;

  tocq_ram #(
    .WIDTH (tocq_pkg::SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_slot    = tocq_pkg::slot_t'(ram_rdata);
  assign in_stall_o = (state_q != tocq_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == tocq_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  assign goes_before = (new_slot_q.tick < rd_slot.tick) ||
                       ((new_slot_q.tick == rd_slot.tick) &&
                        (new_slot_q.prio <= rd_slot.prio));
  assign at_tail     = ((CntW'(idx_q) + CntW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tocq_pkg::ST_IDLE;
      mode_q  <= tocq_pkg::MD_INSERT;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (in_xfer) begin
      new_slot_q.tick <= due_tick_i;
      new_slot_q.prio <= event_priority_i;
      new_slot_q.id   <= event_id_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = new_slot_q;
    ram_raddr    = idx_q;

    case (state_q)
      tocq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_status_d = tocq_pkg::STS_OK;
          res_slot_d   = '0;
          idx_d        = '0;
          case (tocq_pkg::cmd_e'(command_i))
            tocq_pkg::CMD_INSERT: begin
              mode_d = tocq_pkg::MD_INSERT;
              if (count_q == DepthCnt) begin
                res_status_d = tocq_pkg::STS_FULL;
                state_d      = tocq_pkg::ST_DONE;
              end else if (count_q == '0) begin
                state_d = tocq_pkg::ST_WNEW;
              end else begin
                idx_d   = AddrW'(count_q - CntW'(1));
                state_d = tocq_pkg::ST_READ;
              end
            end
            tocq_pkg::CMD_REMOVE: begin
              mode_d = tocq_pkg::MD_SEARCH;
              if (count_q == '0) begin
                res_status_d = tocq_pkg::STS_NOTFOUND;
                state_d      = tocq_pkg::ST_DONE;
              end else begin
                state_d = tocq_pkg::ST_READ;
              end
            end
            tocq_pkg::CMD_POP: begin
              mode_d = tocq_pkg::MD_HEAD;
              if (count_q == '0) begin
                res_status_d = tocq_pkg::STS_EMPTY;
                state_d      = tocq_pkg::ST_DONE;
              end else begin
                state_d = tocq_pkg::ST_READ;
              end
            end
            default: begin
              state_d = tocq_pkg::ST_DONE;
            end
          endcase
        end
      end

      tocq_pkg::ST_READ: begin
        state_d = tocq_pkg::ST_EVAL;
      end

      tocq_pkg::ST_EVAL: begin
        case (mode_q)
          tocq_pkg::MD_INSERT: begin
            ram_we = 1'b1;
            ram_waddr = idx_q + AddrW'(1);
            if (goes_before) begin
              ram_wdata = rd_slot;
              if (idx_q == '0) begin
                state_d = tocq_pkg::ST_WNEW;
              end else begin
                idx_d   = idx_q - AddrW'(1);
                state_d = tocq_pkg::ST_READ;
              end
            end else begin
              count_d = count_q + CntW'(1);
              state_d = tocq_pkg::ST_DONE;
            end
          end
          tocq_pkg::MD_SEARCH: begin
            if (rd_slot.id == new_slot_q.id) begin
              if (at_tail) begin
                count_d = count_q - CntW'(1);
                state_d = tocq_pkg::ST_DONE;
              end else begin
                mode_d  = tocq_pkg::MD_SHIFT;
                idx_d   = idx_q + AddrW'(1);
                state_d = tocq_pkg::ST_READ;
              end
            end else if (at_tail) begin
              res_status_d = tocq_pkg::STS_NOTFOUND;
              state_d      = tocq_pkg::ST_DONE;
            end else begin
              idx_d   = idx_q + AddrW'(1);
              state_d = tocq_pkg::ST_READ;
            end
          end
          tocq_pkg::MD_HEAD: begin
            res_slot_d = rd_slot;
            if (at_tail) begin
              count_d = count_q - CntW'(1);
              state_d = tocq_pkg::ST_DONE;
            end else begin
              mode_d  = tocq_pkg::MD_SHIFT;
              idx_d   = idx_q + AddrW'(1);
              state_d = tocq_pkg::ST_READ;
            end
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = idx_q - AddrW'(1);
            ram_wdata = rd_slot;
            if (at_tail) begin
              count_d = count_q - CntW'(1);
              state_d = tocq_pkg::ST_DONE;
            end else begin
              idx_d   = idx_q + AddrW'(1);
              state_d = tocq_pkg::ST_READ;
            end
          end
        endcase
      end

      tocq_pkg::ST_WNEW: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_slot_q;
        count_d   = count_q + CntW'(1);
        state_d   = tocq_pkg::ST_DONE;
      end

      tocq_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = tocq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tocq_pkg::ST_IDLE;
      end
    endcase
  end

  // output register, refilled when empty or when the held result transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_occ_q    <= tocq_pkg::OCC_W'(count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign head_id_o       = out_slot_q.id;
  assign head_tick_o     = out_slot_q.tick;
  assign head_priority_o = out_slot_q.prio;
  assign occupancy_o     = out_occ_q;

endmodule

// ===== hw/rtl/tocq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tocq_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== test/tocq_checker.sv =====
// result checker for the time ordered event queue core
// keeps its own sorted queue, predicts one result per command transfer and compares
// depends on tocq_pkg
`timescale 1ns / 1ps

module tocq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [1:0]                          command_i,
  input  logic [tocq_pkg::ID_W-1:0]           event_id_i,
  input  logic [tocq_pkg::TICK_W-1:0]         due_tick_i,
  input  logic signed [tocq_pkg::PRIO_W-1:0]  event_priority_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [1:0]                          status_i,
  input  logic [tocq_pkg::ID_W-1:0]           head_id_i,
  input  logic [tocq_pkg::TICK_W-1:0]         head_tick_i,
  input  logic signed [tocq_pkg::PRIO_W-1:0]  head_priority_i,
  input  logic [tocq_pkg::OCC_W-1:0]          occupancy_i,
  output int unsigned                         failures_o,
  output int unsigned                         pending_o
);

  typedef struct packed {
    tocq_pkg::status_e                  status;
    logic [tocq_pkg::ID_W-1:0]          id;
    logic [tocq_pkg::TICK_W-1:0]        tick;
    logic signed [tocq_pkg::PRIO_W-1:0] prio;
    logic [tocq_pkg::OCC_W-1:0]         occ;
  } queue_result_t;

  logic [tocq_pkg::TICK_W-1:0]        sorted_tick [QUEUE_DEPTH];
  logic signed [tocq_pkg::PRIO_W-1:0] sorted_prio [QUEUE_DEPTH];
  logic [tocq_pkg::ID_W-1:0]          sorted_id   [QUEUE_DEPTH];
  int                                 entries = 0;

  queue_result_t            awaited_results [$];
  int unsigned              mismatches = 0;
  int unsigned              pending = 0;

  assign failures_o = mismatches;
  assign pending_o  = pending;

  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < entries; i++) begin
      sorted_tick[i] = sorted_tick[i+1];
      sorted_prio[i] = sorted_prio[i+1];
      sorted_id[i]   = sorted_id[i+1];
    end
    entries--;
  endfunction

  function automatic queue_result_t apply_command(tocq_pkg::cmd_e cmd,
                                                  logic [tocq_pkg::ID_W-1:0] id,
                                                  logic [tocq_pkg::TICK_W-1:0] tick,
                                                  logic signed [tocq_pkg::PRIO_W-1:0] prio);
    queue_result_t res;
    int            pos;
    int            i;
    bit            hit;
    res        = '0;
    res.status = tocq_pkg::STS_OK;
    pos        = 0;
    hit        = 1'b0;
    case (cmd)
      tocq_pkg::CMD_INSERT: begin
        if (entries >= QUEUE_DEPTH) begin
          res.status = tocq_pkg::STS_FULL;
        end else begin
          pos = entries;
          for (i = 0; i < entries; i++) begin
            if (!hit && (tick < sorted_tick[i] ||
                         (tick == sorted_tick[i] && prio <= sorted_prio[i]))) begin
              pos = i;
              hit = 1'b1;
            end
          end
          for (i = entries; i > pos; i--) begin
            sorted_tick[i] = sorted_tick[i-1];
            sorted_prio[i] = sorted_prio[i-1];
            sorted_id[i]   = sorted_id[i-1];
          end
          sorted_tick[pos] = tick;
          sorted_prio[pos] = prio;
          sorted_id[pos]   = id;
          entries++;
        end
      end
      tocq_pkg::CMD_REMOVE: begin
        res.status = tocq_pkg::STS_NOTFOUND;
        for (i = 0; i < entries; i++) begin
          if (!hit && sorted_id[i] == id) begin
            pos = i;
            hit = 1'b1;
          end
        end
        if (hit) begin
          drop_entry(pos);
          res.status = tocq_pkg::STS_OK;
        end
      end
      tocq_pkg::CMD_POP: begin
        if (entries == 0) begin
          res.status = tocq_pkg::STS_EMPTY;
        end else begin
          res.id   = sorted_id[0];
          res.tick = sorted_tick[0];
          res.prio = sorted_prio[0];
          drop_entry(0);
        end
      end
      default: ;
    endcase
    res.occ = tocq_pkg::OCC_W'(entries);
    return res;
  endfunction

  task automatic check_field(string name, logic [tocq_pkg::TICK_W-1:0] want,
                             logic [tocq_pkg::TICK_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      entries = 0;
      awaited_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited_results.insert(awaited_results.size(),
                               apply_command(tocq_pkg::cmd_e'(command_i), event_id_i,
                                             due_tick_i, event_priority_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no command waiting for it");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", tocq_pkg::TICK_W'(want.status), tocq_pkg::TICK_W'(status_i));
          check_field("head_id", tocq_pkg::TICK_W'(want.id), tocq_pkg::TICK_W'(head_id_i));
          check_field("head_tick", want.tick, head_tick_i);
          check_field("head_priority", tocq_pkg::TICK_W'(unsigned'(want.prio)),
                      tocq_pkg::TICK_W'(unsigned'(head_priority_i)));
          check_field("occupancy", tocq_pkg::TICK_W'(want.occ),
                      tocq_pkg::TICK_W'(occupancy_i));
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the time ordered event queue core
// drives directed and random command transfers with random idling on both channels
// depends on tocq_pkg, time_ordered_event_queue_core and tocq_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 127;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  logic                               clk = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [1:0]                         command = tocq_pkg::CMD_NOP;
  logic [tocq_pkg::ID_W-1:0]          event_id = '0;
  logic [tocq_pkg::TICK_W-1:0]        due_tick = '0;
  logic signed [tocq_pkg::PRIO_W-1:0] event_priority = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [1:0]                         status;
  logic [tocq_pkg::ID_W-1:0]          head_id;
  logic [tocq_pkg::TICK_W-1:0]        head_tick;
  logic signed [tocq_pkg::PRIO_W-1:0] head_priority;
  logic [tocq_pkg::OCC_W-1:0]         occupancy;

  int unsigned              failures;
  int unsigned              pending;
  bit                       idling_on = 1'b1;
  bit                       hold_req = 1'b0;

  always #4 clk = ~clk;

  time_ordered_event_queue_core #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .event_id_i       (event_id),
    .due_tick_i       (due_tick),
    .event_priority_i (event_priority),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .head_id_o        (head_id),
    .head_tick_o      (head_tick),
    .head_priority_o  (head_priority),
    .occupancy_o      (occupancy)
  );

  tocq_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .event_id_i       (event_id),
    .due_tick_i       (due_tick),
    .event_priority_i (event_priority),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .head_id_i        (head_id),
    .head_tick_i      (head_tick),
    .head_priority_i  (head_priority),
    .occupancy_i      (occupancy),
    .failures_o       (failures),
    .pending_o        (pending)
  );

  task automatic issue_command(tocq_pkg::cmd_e cmd, logic [tocq_pkg::ID_W-1:0] id,
                               logic [tocq_pkg::TICK_W-1:0] tick,
                               logic signed [tocq_pkg::PRIO_W-1:0] prio);
    @(negedge clk);
    in_valid       <= 1'b1;
    command        <= cmd;
    event_id       <= id;
    due_tick       <= tick;
    event_priority <= prio;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [tocq_pkg::TICK_W-1:0] pick_tick();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom};
      default: return tocq_pkg::TICK_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic signed [tocq_pkg::PRIO_W-1:0] pick_prio();
    if ($urandom_range(0, 2) == 0) return tocq_pkg::PRIO_W'($urandom_range(0, 255));
    return tocq_pkg::PRIO_W'($urandom_range(0, 4) - 2);
  endfunction

  function automatic logic [tocq_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return tocq_pkg::ID_W'($urandom_range(0, 255));
    return tocq_pkg::ID_W'($urandom_range(0, 15));
  endfunction

  // receiver side: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned    phase;
    int unsigned    n;
    int unsigned    roll;
    int unsigned    ins_pct;
    tocq_pkg::cmd_e cmd;

    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;

    // empty queue cases and the unused code
    issue_command(tocq_pkg::CMD_POP, 8'h00, '0, 8'h00);
    issue_command(tocq_pkg::CMD_REMOVE, 8'hFF, '1, 8'hFF);
    issue_command(tocq_pkg::CMD_NOP, 8'hA5, {2{32'h5A5A_A5A5}}, 8'h55);
    // field extremes, equal keys, duplicate ids
    issue_command(tocq_pkg::CMD_INSERT, 8'hFF, '1, 8'h7F);
    issue_command(tocq_pkg::CMD_INSERT, 8'h00, '0, 8'h80);
    issue_command(tocq_pkg::CMD_INSERT, 8'h01, '0, 8'h80);
    issue_command(tocq_pkg::CMD_INSERT, 8'h07, 64'd5, 8'h03);
    issue_command(tocq_pkg::CMD_INSERT, 8'h07, 64'd5, 8'h03);
    issue_command(tocq_pkg::CMD_REMOVE, 8'h07, '0, 8'h00);
    issue_command(tocq_pkg::CMD_REMOVE, 8'hC8, '0, 8'h00);
    // fill up, then one insert past full
    for (n = 0; n < DEPTH - 4; n++) begin
      issue_command(tocq_pkg::CMD_INSERT, tocq_pkg::ID_W'(n + 16), pick_tick(), pick_prio());
    end
    issue_command(tocq_pkg::CMD_INSERT, 8'h3C, 64'd1, 8'h00);
    issue_command(tocq_pkg::CMD_POP, 8'h00, '0, 8'h00);
    issue_command(tocq_pkg::CMD_POP, 8'h00, '0, 8'h00);

    for (phase = 0; phase < PHASES; phase++) begin
      idling_on = (phase != 5 && phase != PHASES - 1);
      case (phase % 4)
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        2:       ins_pct = 50;
        default: ins_pct = 65;
      endcase
      if (phase == 3) hold_req = 1'b1;
      if (phase == 7) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) cmd = tocq_pkg::CMD_INSERT;
        else if (roll < ins_pct + (97 - ins_pct) / 2) cmd = tocq_pkg::CMD_POP;
        else if (roll < 97) cmd = tocq_pkg::CMD_REMOVE;
        else cmd = tocq_pkg::CMD_NOP;
        issue_command(cmd, pick_id(), pick_tick(), pick_prio());
        if (idling_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 11));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
